/* hw/rtl/tmd_pkg.sv */
// shared types and constants of the tagged message deframer
package tmd_pkg;

   localparam int BUFFER_SIZE_DEFAULT = 64;
   localparam int IDX_W = 6;

   localparam logic [7:0] CHAR_S = 8'h53;
   localparam logic [7:0] CHAR_T = 8'h54;
   localparam logic [7:0] CHAR_E = 8'h45;

   typedef enum logic [2:0] {
      PH_START_S  = 3'd0,
      PH_START_T  = 3'd1,
      PH_START_ID = 3'd2,
      PH_END_E    = 3'd3,
      PH_END_T    = 3'd4,
      PH_END_ID   = 3'd5
   } phase_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } wr_type;

   typedef struct packed {
      logic             go;
      logic [7:0]       id;
      logic [IDX_W-1:0] len;
   } start_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } rd_type;

endpackage

/* hw/rtl/tmd_store.sv */
// payload store: one write port, one registered read port
module tmd_store #(
   parameter int BUFFER_SIZE = tmd_pkg::BUFFER_SIZE_DEFAULT
) (
   input  logic            clock,
   input  tmd_pkg::wr_type wr,
   input  tmd_pkg::rd_type rd,
   output logic [7:0]      rd_data
);
   import tmd_pkg::*;

   localparam int AW = $clog2(BUFFER_SIZE);

   logic [7:0] mem_ff [BUFFER_SIZE];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tmd_parser.sv */
// frame parser: start and end detection, payload writes, put-back of false ends
module tmd_parser #(
   parameter int BUFFER_SIZE = tmd_pkg::BUFFER_SIZE_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_stream_byte,
   input  logic               readout_busy,
   output tmd_pkg::wr_type    wr,
   output tmd_pkg::start_type start
);
   import tmd_pkg::*;

   localparam logic [IDX_W-1:0] ROOM_LIMIT = IDX_W'(BUFFER_SIZE - 4);

   phase_type        phase_ff, phase_in;
   logic [7:0]       open_id_ff, open_id_in;
   logic [IDX_W-1:0] fill_ff, fill_in;
   logic [7:0]       pend0_ff, pend0_in;
   logic [7:0]       pend1_ff, pend1_in;
   logic [1:0]       pend_cnt_ff, pend_cnt_in;
   logic             accept;
   logic             room;

   assign req_stall = readout_busy || (pend_cnt_ff != 2'd0);
   assign accept    = req_valid && !req_stall;
   assign room      = fill_ff < ROOM_LIMIT;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START_S;
         open_id_ff  <= 8'd0;
         fill_ff     <= '0;
         pend_cnt_ff <= 2'd0;
      end else begin
         phase_ff    <= phase_in;
         open_id_ff  <= open_id_in;
         fill_ff     <= fill_in;
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

   always_comb begin
      phase_in    = phase_ff;
      open_id_in  = open_id_ff;
      fill_in     = fill_ff;
      pend0_in    = pend0_ff;
      pend1_in    = pend1_ff;
      pend_cnt_in = pend_cnt_ff;
      wr.en       = 1'b0;
      wr.addr     = fill_ff;
      wr.data     = req_stream_byte;
      start.go    = 1'b0;
      start.id    = open_id_ff;
      start.len   = fill_ff;

      if (pend_cnt_ff != 2'd0) begin
         // drain the rest of a put-back sequence, one byte a cycle
         wr.en       = 1'b1;
         wr.data     = pend0_ff;
         fill_in     = fill_ff + 1'b1;
         pend0_in    = pend1_ff;
         pend_cnt_in = pend_cnt_ff - 2'd1;
      end else if (accept) begin
         case (phase_ff)
            PH_START_T: begin
               phase_in = (req_stream_byte == CHAR_T) ? PH_START_ID : PH_START_S;
            end
            PH_START_ID: begin
               open_id_in = req_stream_byte;
               fill_in    = '0;
               phase_in   = PH_END_E;
            end
            PH_END_E: begin
               if (req_stream_byte == CHAR_E) begin
                  phase_in = PH_END_T;
               end else if (room) begin
                  wr.en   = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
            end
            PH_END_T: begin
               if (req_stream_byte == CHAR_T) begin
                  phase_in = PH_END_ID;
               end else begin
                  if (room) begin
                     wr.en       = 1'b1;
                     wr.data     = CHAR_E;
                     fill_in     = fill_ff + 1'b1;
                     pend0_in    = req_stream_byte;
                     pend_cnt_in = 2'd1;
                  end
                  phase_in = PH_END_E;
               end
            end
            PH_END_ID: begin
               if (req_stream_byte == open_id_ff) begin
                  start.go = 1'b1;
                  phase_in = PH_START_S;
               end else begin
                  if (room) begin
                     wr.en       = 1'b1;
                     wr.data     = CHAR_E;
                     fill_in     = fill_ff + 1'b1;
                     pend0_in    = CHAR_T;
                     pend1_in    = req_stream_byte;
                     pend_cnt_in = 2'd2;
                  end
                  phase_in = PH_END_E;
               end
            end
            default: begin
               phase_in = (req_stream_byte == CHAR_S) ? PH_START_T : PH_START_S;
            end
         endcase
      end
   end

endmodule

/* hw/rtl/tmd_readout.sv */
// frame readout: read sequencer, read data stage and output register
module tmd_readout (
   input  logic               clock,
   input  logic               reset,
   input  tmd_pkg::start_type start,
   output logic               busy,
   output tmd_pkg::rd_type    rd,
   input  logic [7:0]         rd_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_payload_byte,
   output logic [7:0]         rsp_frame_id,
   output logic [5:0]         rsp_frame_length,
   output logic               rsp_empty_frame,
   output logic               rsp_last
);
   import tmd_pkg::*;

   logic             active_ff;
   logic [IDX_W-1:0] next_ff;
   logic [IDX_W-1:0] len_ff;
   logic [7:0]       id_ff;
   logic             s1_valid_ff, s1_last_ff, s1_empty_ff;
   logic             out_valid_ff;
   logic [7:0]       out_byte_ff, out_id_ff;
   logic [IDX_W-1:0] out_len_ff;
   logic             out_empty_ff, out_last_ff;
   logic             advance;
   logic             issue;
   logic             issue_last;

   assign advance    = !out_valid_ff || !rsp_stall;
   assign issue      = active_ff && (!s1_valid_ff || advance);
   assign issue_last = (len_ff == '0) || (next_ff + 1'b1 == len_ff);

   assign rd.en   = issue;
   assign rd.addr = next_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (start.go) begin
            active_ff <= 1'b1;
         end else if (issue && issue_last) begin
            active_ff <= 1'b0;
         end
         if (issue) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start.go) begin
         next_ff <= '0;
         len_ff  <= start.len;
         id_ff   <= start.id;
      end else if (issue) begin
         next_ff <= next_ff + 1'b1;
      end
      if (issue) begin
         s1_last_ff  <= issue_last;
         s1_empty_ff <= (len_ff == '0);
      end
      if (advance && s1_valid_ff) begin
         out_byte_ff  <= s1_empty_ff ? 8'd0 : rd_data;
         out_id_ff    <= id_ff;
         out_len_ff   <= len_ff;
         out_empty_ff <= s1_empty_ff;
         out_last_ff  <= s1_last_ff;
      end
   end

   assign busy             = active_ff || s1_valid_ff || out_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_frame_id     = out_id_ff;
   assign rsp_frame_length = out_len_ff;
   assign rsp_empty_frame  = out_empty_ff;
   assign rsp_last         = out_last_ff;

endmodule

/* hw/rtl/tagged_message_deframer.sv */
// tagged message deframer top level
// first result word of a frame: active flag, store read register, output register
// throughput: one stream word a cycle; input is held while put-back words are written
// readout, when rsp_stall is low, gives one result word a cycle from the store's
// registered read port; input is held until the last result word of the frame is taken
// reset: synchronous, active high; clears parser phase, id, fill index and readout control
module tagged_message_deframer #(
   parameter int BUFFER_SIZE = tmd_pkg::BUFFER_SIZE_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_stream_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_frame_id,
   output logic [5:0] rsp_frame_length,
   output logic       rsp_empty_frame,
   output logic       rsp_last
);
   import tmd_pkg::*;

   wr_type     wr;
   rd_type     rd;
   start_type  start;
   logic [7:0] rd_data;
   logic       busy;

   // parser owns the write side of the store
   tmd_parser #(.BUFFER_SIZE(BUFFER_SIZE)) u_parser (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .readout_busy    (busy),
      .wr              (wr),
      .start           (start)
   );

   // store contents are undefined until written; empty frames send zero, not store data
   tmd_store #(.BUFFER_SIZE(BUFFER_SIZE)) u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   // reads start only after the closing id, so no write to the same entry can overlap;
   // input is held during readout, which stands in for forwarding
   tmd_readout u_readout (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .rd               (rd),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_id     (rsp_frame_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_empty_frame  (rsp_empty_frame),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   // no stream word may enter while a frame is being read out
   a_hold_during_readout: assert property (@(posedge clock) disable iff (reset)
      busy |-> req_stall)
      else $error("stream word accepted during readout");

   // a completed frame starts the readout on the next cycle
   a_start_readout: assert property (@(posedge clock) disable iff (reset)
      start.go |=> busy)
      else $error("frame completed but readout idle");

   // an empty frame is a single result word
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_frame) |-> rsp_last)
      else $error("empty frame result not marked last");

   // id and length stay fixed across the words of one frame
   a_frame_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last)
      |=> ($stable(rsp_frame_id) && $stable(rsp_frame_length)))
      else $error("frame id or length changed inside a frame");
`endif

endmodule

/* test/tmd_checker.sv */
// checker for the tagged message deframer: tracks the framing and compares result words
module deframe_checker
   import tmd_pkg::*;
#(
   parameter int BUFFER_SIZE = BUFFER_SIZE_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_stream_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_payload_byte,
   input  logic [7:0] rsp_frame_id,
   input  logic [5:0] rsp_frame_length,
   input  logic       rsp_empty_frame,
   input  logic       rsp_last,
   output int         outstanding,
   output int         fail_count
);

   typedef struct {
      logic [7:0] payload_byte;
      logic [7:0] frame_id;
      logic [5:0] frame_length;
      logic       empty_frame;
      logic       last;
   } frame_word_type;

   frame_word_type frame_words[$];

   phase_type  phase;
   logic [7:0] open_id;
   logic [5:0] fill_index;
   logic [7:0] payload_store [0:63];

   initial begin
      outstanding = 0;
      fail_count  = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("deframer check @%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
      end
   endtask

   function automatic bit room_left();
      return fill_index < BUFFER_SIZE - 4;
   endfunction

   task automatic store_byte(input logic [7:0] b);
      payload_store[fill_index] = b;
      fill_index = fill_index + 6'd1;
   endtask

   task automatic queue_frame();
      frame_word_type w;
      w.frame_id     = open_id;
      w.frame_length = fill_index;
      if (fill_index == 6'd0) begin
         w.payload_byte = 8'h00;
         w.empty_frame  = 1'b1;
         w.last         = 1'b1;
         frame_words.push_back(w);
      end else begin
         for (int k = 0; k < fill_index; k++) begin
            w.payload_byte = payload_store[k];
            w.empty_frame  = 1'b0;
            w.last         = (k + 1 == fill_index);
            frame_words.push_back(w);
         end
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      case (phase)
         PH_START_T: begin
            phase = (b == CHAR_T) ? PH_START_ID : PH_START_S;
         end
         PH_START_ID: begin
            open_id    = b;
            fill_index = 6'd0;
            phase      = PH_END_E;
         end
         PH_END_E: begin
            if (b == CHAR_E) phase = PH_END_T;
            else if (room_left()) store_byte(b);
         end
         PH_END_T: begin
            if (b == CHAR_T) begin
               phase = PH_END_ID;
            end else begin
               if (room_left()) begin
                  store_byte(CHAR_E);
                  store_byte(b);
               end
               phase = PH_END_E;
            end
         end
         PH_END_ID: begin
            if (b == open_id) begin
               phase = PH_START_S;
               queue_frame();
            end else begin
               if (room_left()) begin
                  store_byte(CHAR_E);
                  store_byte(CHAR_T);
                  store_byte(b);
               end
               phase = PH_END_E;
            end
         end
         default: begin
            phase = (b == CHAR_S) ? PH_START_T : PH_START_S;
         end
      endcase
   endtask

   always @(posedge clock) begin
      frame_word_type w;
      if (reset) begin
         phase      = PH_START_S;
         open_id    = 8'h00;
         fill_index = 6'd0;
         frame_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_words.size() == 0) begin
               report_mismatch("result word with none expected");
            end else begin
               w = frame_words.pop_front();
               check_field("payload_byte", rsp_payload_byte, w.payload_byte);
               check_field("frame_id", rsp_frame_id, w.frame_id);
               check_field("frame_length", 8'(rsp_frame_length), 8'(w.frame_length));
               check_field("empty_frame", 8'(rsp_empty_frame), 8'(w.empty_frame));
               check_field("last", 8'(rsp_last), 8'(w.last));
            end
         end
         if (req_valid && !req_stall) deframe_byte(req_stream_byte);
      end
      outstanding <= frame_words.size();
   end

endmodule

/* test/tb.sv */
// testbench top for the tagged message deframer: stimulus, flow control and verdict
module tb;
   import tmd_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int ITEM_TARGET    = 450;   // stream words, roughly
   localparam int DRAIN_CYCLES   = 20;    // settling time after the last word

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_stream_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_frame_id;
   logic [5:0] rsp_frame_length;
   logic       rsp_empty_frame;
   logic       rsp_last;

   // flow control knobs, percentages per cycle
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;

   // one long hold-off of the result side, counted down by the receiver process
   logic hold_go    = 1'b0;
   bit   hold_taken = 1'b0;
   int   hold_left  = 0;

   int outstanding;
   int fail_count;
   int quiet_cycles = 0;
   int words_sent   = 0;

   always #5 clock = ~clock;

   tagged_message_deframer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_id     (rsp_frame_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_empty_frame  (rsp_empty_frame),
      .rsp_last         (rsp_last)
   );

   deframe_checker #(
      .BUFFER_SIZE (BUFFER_SIZE_DEFAULT)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_id     (rsp_frame_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_empty_frame  (rsp_empty_frame),
      .rsp_last         (rsp_last),
      .outstanding      (outstanding),
      .fail_count       (fail_count)
   );

   // result side: a single long hold-off when asked, otherwise random stalls
   always @(posedge clock) begin
      if (hold_go && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
      end
   end

   // watchdog: any accepted word on either side counts as progress
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tagged_message_deframer: mismatch");
            $finish;
         end
      end
   end

   // offer one stream word, with random idle cycles ahead of it, and wait for acceptance
   task automatic send_word(input logic [7:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid       <= 1'b0;
         req_stream_byte <= 8'($urandom());  // data is don't-care while idle
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // sender goes quiet until every predicted result word has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // one well-formed frame with random content, sprinkled with false end sequences
   task automatic send_frame(input int min_len, input int max_len);
      logic [7:0] id;
      logic [7:0] other;
      int         n;
      int         k;
      int         pick;
      id = 8'($urandom());
      n  = $urandom_range(max_len, min_len);
      k  = 0;
      send_word(CHAR_S);
      send_word(CHAR_T);
      send_word(id);
      while (k < n) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            // plain payload word
            send_word(8'($urandom()));
            k += 1;
         end else if (pick < 80) begin
            // lone end letter followed by anything
            send_word(CHAR_E);
            send_word(8'($urandom()));
            k += 2;
         end else if (pick < 90) begin
            // full end sequence with the wrong id, put back into the payload
            other = id ^ 8'($urandom_range(255, 1));
            send_word(CHAR_E);
            send_word(CHAR_T);
            send_word(other);
            k += 3;
         end else if (pick < 95) begin
            // doubled end letter
            send_word(CHAR_E);
            send_word(CHAR_E);
            k += 2;
         end else begin
            // start letters inside the payload are just data
            send_word($urandom_range(1) ? CHAR_S : CHAR_T);
            k += 1;
         end
      end
      send_word(CHAR_E);
      send_word(CHAR_T);
      send_word(id);
   endtask

   // stray words between frames, including broken starts
   task automatic send_noise();
      int n;
      n = $urandom_range(6, 1);
      repeat (n) begin
         case ($urandom_range(3))
            0:       send_word(CHAR_S);
            1:       send_word(CHAR_T);
            default: send_word(8'($urandom()));
         endcase
      end
   endtask

   initial begin
      logic [7:0] directed [] = '{
         // wrong start letter
         CHAR_S, 8'h58,
         // doubled start letter drops the start, a third one opens an empty frame
         // with id zero
         CHAR_S, CHAR_S, CHAR_S, CHAR_T, 8'h00, CHAR_E, CHAR_T, 8'h00,
         // id 0xff, extreme payload words, doubled end letter, lone end letter,
         // end sequence with the wrong id, then the real close
         CHAR_S, CHAR_T, 8'hff, 8'h00, 8'hff, CHAR_E, CHAR_E, CHAR_E, 8'h41,
         CHAR_E, CHAR_T, 8'h01, CHAR_E, CHAR_T, 8'hff
      };
      int pick;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed words with no idling on either side
      foreach (directed[i]) send_word(directed[i]);

      // long receiver hold-off: the first frame stalls readout and the block
      // backs up onto its input while the sender keeps offering
      hold_go <= 1'b1;
      repeat (3) send_frame(0, 6);
      // sender pause until everything has drained
      wait_for_results();

      // random phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 46; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 46; end
            default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
         endcase
         while (words_sent < (ph + 1) * ITEM_TARGET / 4) begin
            pick = $urandom_range(99);
            // long frames fill the store so put-backs meet the full condition
            if (pick < 4) send_frame(56, 72);
            else if (pick < 14) send_noise();
            else send_frame(0, 10);
         end
         wait_for_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tagged_message_deframer: match");
      end else begin
         $display("tagged_message_deframer: mismatch");
      end
      $finish;
   end

endmodule
